[src/pis_pkg.sv]
`timescale 1ns / 1ps

package pis_pkg;

    localparam int NUM_SRC   = 28;
    localparam int SRC_W     = 5;
    localparam int LVL_W     = 4;
    localparam int NUM_LVL   = 16;
    localparam int CODE_W    = 12;
    localparam int CMD_W     = 3;
    localparam int PRIO_W    = 16;
    localparam int CFG_IDX_W = 2;
    localparam int NIB_W     = 2;

    localparam int IN_DATA_W   = 16;
    localparam int IN_USER_W   = CMD_W;
    localparam int OUT_DATA_W  = 24;
    localparam int OUT_USER_W  = 1;

    localparam logic [PRIO_W-1:0] FIXED_LEVELS = 16'h0246;

    typedef enum logic [CMD_W-1:0] {
        CMD_POLL     = 3'd0,
        CMD_SET_PEND = 3'd1,
        CMD_CLR_PEND = 3'd2,
        CMD_ENABLE   = 3'd3,
        CMD_DISABLE  = 3'd4
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PRIO_A = 2'd0,
        CFG_PRIO_B = 2'd1,
        CFG_PRIO_C = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        LSRC_FIXED = 2'd0,
        LSRC_A     = 2'd1,
        LSRC_B     = 2'd2,
        LSRC_C     = 2'd3
    } t_lvl_src;

    typedef struct packed {
        logic              request;
        logic [SRC_W-1:0]  source;
        logic [LVL_W-1:0]  level;
        logic [CODE_W-1:0] code;
    } t_sel_result;

    localparam t_lvl_src SRC_REG [NUM_SRC] = '{
        LSRC_FIXED, LSRC_FIXED, LSRC_FIXED,
        LSRC_C,
        LSRC_C,
        LSRC_C, LSRC_C, LSRC_C, LSRC_C, LSRC_C,
        LSRC_A, LSRC_A, LSRC_A, LSRC_A,
        LSRC_A, LSRC_A, LSRC_A,
        LSRC_B, LSRC_B, LSRC_B, LSRC_B,
        LSRC_C, LSRC_C, LSRC_C, LSRC_C,
        LSRC_B,
        LSRC_B, LSRC_B
    };

    localparam logic [NIB_W-1:0] SRC_NIB [NUM_SRC] = '{
        2'd0, 2'd1, 2'd2,
        2'd0,
        2'd3,
        2'd2, 2'd2, 2'd2, 2'd2, 2'd2,
        2'd3, 2'd2, 2'd1, 2'd1,
        2'd0, 2'd0, 2'd0,
        2'd1, 2'd1, 2'd1, 2'd1,
        2'd1, 2'd1, 2'd1, 2'd1,
        2'd3,
        2'd2, 2'd2
    };

    localparam logic [CODE_W-1:0] SRC_CODE [NUM_SRC] = '{
        12'h320, 12'h360, 12'h3A0,
        12'h600,
        12'h620,
        12'h640, 12'h660, 12'h680, 12'h6A0, 12'h6C0,
        12'h400, 12'h420, 12'h440, 12'h460,
        12'h480, 12'h4A0, 12'h4C0,
        12'h4E0, 12'h500, 12'h520, 12'h540,
        12'h700, 12'h720, 12'h740, 12'h760,
        12'h560,
        12'h580, 12'h5A0
    };

endpackage

[src/pis_select.sv]
`timescale 1ns / 1ps

module pis_select
    import pis_pkg::*;
(
    input  logic [NUM_SRC-1:0] i_elig,
    input  logic [PRIO_W-1:0]  i_prio_a,
    input  logic [PRIO_W-1:0]  i_prio_b,
    input  logic [PRIO_W-1:0]  i_prio_c,
    input  logic               i_blk,
    input  logic [LVL_W-1:0]   i_mask,
    output t_sel_result        o_sel
);

    logic [LVL_W-1:0]   lvl [NUM_SRC];
    logic [NUM_SRC-1:0] cand;
    logic [NUM_SRC-1:0] hit;
    logic [NUM_LVL-1:0] lvl_seen;
    logic [LVL_W-1:0]   best_lvl;
    logic [SRC_W-1:0]   best_src;
    logic               req;

    always_comb begin
        logic [PRIO_W-1:0] word;
        for (int s = 0; s < NUM_SRC; s++) begin
            case (SRC_REG[s])
                LSRC_A:  word = i_prio_a;
                LSRC_B:  word = i_prio_b;
                LSRC_C:  word = i_prio_c;
                default: word = FIXED_LEVELS;
            endcase
            lvl[s]  = word[LVL_W*SRC_NIB[s] +: LVL_W];
            cand[s] = i_elig[s] && !i_blk && (lvl[s] > i_mask);
        end
    end

    always_comb begin
        lvl_seen = '0;
        for (int l = 0; l < NUM_LVL; l++) begin
            for (int s = 0; s < NUM_SRC; s++) begin
                if (cand[s] && (lvl[s] == LVL_W'(l))) begin
                    lvl_seen[l] = 1'b1;
                end
            end
        end
    end

    always_comb begin
        best_lvl = '0;
        for (int l = 0; l < NUM_LVL; l++) begin
            if (lvl_seen[l]) begin
                best_lvl = LVL_W'(l);
            end
        end
    end

    always_comb begin
        best_src = '0;
        for (int s = 0; s < NUM_SRC; s++) begin
            hit[s] = cand[s] && (lvl[s] == best_lvl);
            if (hit[s]) begin
                best_src = SRC_W'(s);
            end
        end
    end

    assign req = |cand;

    always_comb begin
        o_sel.request = req;
        o_sel.source  = req ? best_src : '0;
        o_sel.level   = req ? best_lvl : '0;
        o_sel.code    = req ? SRC_CODE[best_src] : '0;
    end

endmodule

[src/priority_interrupt_selector_core.sv]
`timescale 1ns / 1ps
// channel    handshake                      payload
// s_axis     s_axis_tvalid / s_axis_tready   tdata: index, block, mask; tuser: command
// m_axis     m_axis_tvalid / m_axis_tready   tdata: source, level, code; tuser: request
// cfg        i_cfg_valid / o_cfg_ready       i_cfg_index, i_cfg_data
//
// One word per cycle while the result is not stalled; a word taken at s_axis passes the
// input register, then the update and selection into the result register, before m_axis.
// Synchronous active-low reset: pending bits cleared, enable bits set,
// priority registers zero. A stalled result holds; the input register
// still fills behind it, after which s_axis_tready follows m_axis_tready.
// The config port is always ready.

module priority_interrupt_selector_core
    import pis_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [4:0] source_index, [5] cpu_block, [9:6] cpu_level_mask, [15:10] zero
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // [2:0] command
    input  logic [IN_USER_W-1:0]  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [4:0] winner_source, [8:5] winner_level, [20:9] event_code, [23:21] zero
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // [0] request
    output logic [OUT_USER_W-1:0] m_axis_tuser,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [PRIO_W-1:0]     i_cfg_data
);

    logic               r_in_vld;
    logic [CMD_W-1:0]   r_cmd;
    logic [SRC_W-1:0]   r_idx;
    logic               r_blk;
    logic [LVL_W-1:0]   r_mask;
    logic [NUM_SRC-1:0] r_pend;
    logic [NUM_SRC-1:0] r_enab;
    logic [NUM_SRC-1:0] n_pend;
    logic [NUM_SRC-1:0] n_enab;
    logic [PRIO_W-1:0]  r_prio_a;
    logic [PRIO_W-1:0]  r_prio_b;
    logic [PRIO_W-1:0]  r_prio_c;
    logic               r_out_vld;
    t_sel_result        r_out;
    t_sel_result        sel;
    logic               adv;
    logic               in_ready;
    logic [NUM_SRC-1:0] bit_sel;

    assign adv           = !r_out_vld || m_axis_tready;
    assign in_ready      = !r_in_vld || adv;
    assign s_axis_tready = in_ready;
    assign o_cfg_ready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_ready) begin
            r_in_vld <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && s_axis_tvalid) begin
            r_cmd  <= s_axis_tuser[CMD_W-1:0];
            r_idx  <= s_axis_tdata[SRC_W-1:0];
            r_blk  <= s_axis_tdata[SRC_W];
            r_mask <= s_axis_tdata[SRC_W+1 +: LVL_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prio_a <= '0;
            r_prio_b <= '0;
            r_prio_c <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_PRIO_A: r_prio_a <= i_cfg_data;
                CFG_PRIO_B: r_prio_b <= i_cfg_data;
                CFG_PRIO_C: r_prio_c <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        bit_sel = (r_idx < SRC_W'(NUM_SRC)) ? (NUM_SRC'(1) << r_idx) : '0;
        n_pend  = r_pend;
        n_enab  = r_enab;
        case (r_cmd)
            CMD_SET_PEND: n_pend = r_pend | bit_sel;
            CMD_CLR_PEND: n_pend = r_pend & ~bit_sel;
            CMD_ENABLE:   n_enab = r_enab | bit_sel;
            CMD_DISABLE:  n_enab = r_enab & ~bit_sel;
            default: ;
        endcase
    end

    pis_select u_select (
        .i_elig   (n_pend & n_enab),
        .i_prio_a (r_prio_a),
        .i_prio_b (r_prio_b),
        .i_prio_c (r_prio_c),
        .i_blk    (r_blk),
        .i_mask   (r_mask),
        .o_sel    (sel)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend    <= '0;
            r_enab    <= '1;
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= r_in_vld;
            if (r_in_vld) begin
                r_pend <= n_pend;
                r_enab <= n_enab;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_in_vld) begin
            r_out <= sel;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {3'b000, r_out.code, r_out.level, r_out.source};
    assign m_axis_tuser  = r_out.request;

endmodule

[src/pis_checker.sv]
`timescale 1ns / 1ps

module pis_checker
    import pis_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  s_axis_tready,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata,
    input logic [OUT_USER_W-1:0] m_axis_tuser
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result word changed");

    a_no_req_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == '0)
        else $error("result fields nonzero without request");

    a_req_sane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |->
            (m_axis_tdata[SRC_W-1:0] < SRC_W'(NUM_SRC)) &&
            (m_axis_tdata[SRC_W +: LVL_W] != '0))
        else $error("request with bad source or zero level");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled without a stalled result");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

endmodule

bind priority_interrupt_selector_core pis_checker u_pis_checker (.*);

[verif/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
    import pis_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    localparam logic [CMD_W-1:0]     CMD_RSVD_LO  = 3'd5;
    localparam logic [CMD_W-1:0]     CMD_RSVD_MID = 3'd6;
    localparam logic [CMD_W-1:0]     CMD_RSVD_HI  = 3'd7;
    localparam logic [CFG_IDX_W-1:0] CFG_NONE     = 2'd3;

    localparam int RX_ALWAYS  = 0;
    localparam int RX_RANDOM  = 1;
    localparam int RX_PATTERN = 2;

    localparam t_lvl_src LVL_SEL [NUM_SRC] = '{
        LSRC_FIXED, LSRC_FIXED, LSRC_FIXED,
        LSRC_C, LSRC_C,
        LSRC_C, LSRC_C, LSRC_C, LSRC_C, LSRC_C,
        LSRC_A, LSRC_A, LSRC_A, LSRC_A,
        LSRC_A, LSRC_A, LSRC_A,
        LSRC_B, LSRC_B, LSRC_B, LSRC_B,
        LSRC_C, LSRC_C, LSRC_C, LSRC_C,
        LSRC_B, LSRC_B, LSRC_B
    };

    localparam int LVL_SHIFT [NUM_SRC] = '{
        0, 4, 8,
        0, 12,
        8, 8, 8, 8, 8,
        12, 8, 4, 4,
        0, 0, 0,
        4, 4, 4, 4,
        4, 4, 4, 4,
        12, 8, 8
    };

    localparam logic [CODE_W-1:0] EVENT_OF [NUM_SRC] = '{
        12'h320, 12'h360, 12'h3A0,
        12'h600, 12'h620,
        12'h640, 12'h660, 12'h680, 12'h6A0, 12'h6C0,
        12'h400, 12'h420, 12'h440, 12'h460,
        12'h480, 12'h4A0, 12'h4C0,
        12'h4E0, 12'h500, 12'h520, 12'h540,
        12'h700, 12'h720, 12'h740, 12'h760,
        12'h560, 12'h580, 12'h5A0
    };

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;   // [4:0] source_index, [5] cpu_block, [9:6] mask
    logic [IN_USER_W-1:0]  s_axis_tuser;   // [2:0] command
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;   // [4:0] source, [8:5] level, [20:9] event_code
    logic [OUT_USER_W-1:0] m_axis_tuser;   // [0] request
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [PRIO_W-1:0]     i_cfg_data;

    logic [NUM_SRC-1:0] pend_bits;
    logic [NUM_SRC-1:0] en_bits;
    logic [PRIO_W-1:0]  prio_a;
    logic [PRIO_W-1:0]  prio_b;
    logic [PRIO_W-1:0]  prio_c;
    t_sel_result        sel_expect_q [$];

    int err_cnt     = 0;
    int words_sent  = 0;
    int words_seen  = 0;
    int cfg_writes  = 0;
    int cycle_cnt   = 0;
    int burst_left  = 0;
    bit tx_bursty   = 1'b1;
    int rx_mode     = RX_ALWAYS;
    logic [15:0] rx_pat = 16'hA5C3;
    int hold_req    = 0;

    priority_interrupt_selector_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin : watchdog
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("timeout after %0d cycles, %0d words outstanding", cycle_cnt,
                 sel_expect_q.size());
        $display("TB_ERROR");
        $finish;
    end

    function automatic logic [LVL_W-1:0] src_level(input int s);
        logic [PRIO_W-1:0] word;
        case (LVL_SEL[s])
            LSRC_A:  word = prio_a;
            LSRC_B:  word = prio_b;
            LSRC_C:  word = prio_c;
            default: word = FIXED_LEVELS;
        endcase
        return LVL_W'(word >> LVL_SHIFT[s]);
    endfunction

    task automatic predict_selection(input logic [CMD_W-1:0] cmd, input logic [SRC_W-1:0] idx,
                                     input logic blk, input logic [LVL_W-1:0] mask);
        t_sel_result        r;
        logic [NUM_SRC-1:0] elig;
        logic [LVL_W-1:0]   lvl;
        r = '0;
        if (idx < NUM_SRC) begin
            case (cmd)
                CMD_SET_PEND: pend_bits[idx] = 1'b1;
                CMD_CLR_PEND: pend_bits[idx] = 1'b0;
                CMD_ENABLE:   en_bits[idx]   = 1'b1;
                CMD_DISABLE:  en_bits[idx]   = 1'b0;
                default: ;
            endcase
        end
        elig = pend_bits & en_bits;
        if (!blk) begin
            for (int s = 0; s < NUM_SRC; s++) begin
                if (elig[s]) begin
                    lvl = src_level(s);
                    if (lvl > mask && (!r.request || lvl >= r.level)) begin
                        r.request = 1'b1;
                        r.source  = SRC_W'(s);
                        r.level   = lvl;
                        r.code    = EVENT_OF[s];
                    end
                end
            end
        end
        sel_expect_q.push_back(r);
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch on %s at word %0d: got 0x%0h, want 0x%0h (t=%0t)",
                 what, words_seen, got, want, $realtime);
        err_cnt++;
    endtask

    task automatic check_result();
        t_sel_result want;
        if (sel_expect_q.size() == 0) begin
            report_mismatch("unexpected word", m_axis_tdata, 0);
            return;
        end
        want = sel_expect_q.pop_front();
        if (m_axis_tuser[0] !== want.request)
            report_mismatch("request", m_axis_tuser[0], want.request);
        if (m_axis_tdata[4:0] !== want.source)
            report_mismatch("winner_source", m_axis_tdata[4:0], want.source);
        if (m_axis_tdata[8:5] !== want.level)
            report_mismatch("winner_level", m_axis_tdata[8:5], want.level);
        if (m_axis_tdata[20:9] !== want.code)
            report_mismatch("event_code", m_axis_tdata[20:9], want.code);
        words_seen++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) check_result();
    end

    initial begin : rx_side
        int hold_left;
        hold_left = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req > 0) begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                case (rx_mode)
                    RX_RANDOM:  m_axis_tready <= ($urandom_range(0, 99) >= 35);
                    RX_PATTERN: begin
                        m_axis_tready <= rx_pat[0];
                        rx_pat = {rx_pat[0], rx_pat[15:1]};
                    end
                    default:    m_axis_tready <= 1'b1;
                endcase
            end
        end
    end

    task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [SRC_W-1:0] idx,
                             input logic blk, input logic [LVL_W-1:0] mask);
        int gap;
        gap = 0;
        if (tx_bursty) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 12);
                gap        = $urandom_range(1, 6);
            end
            burst_left--;
        end
        repeat (gap) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'b0, mask, blk, idx};
        s_axis_tuser  <= cmd;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_selection(cmd, idx, blk, mask);
        words_sent++;
    endtask

    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (sel_expect_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_prio(input logic [CFG_IDX_W-1:0] idx, input logic [PRIO_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_PRIO_A: prio_a = val;
            CFG_PRIO_B: prio_b = val;
            CFG_PRIO_C: prio_c = val;
            default: ;
        endcase
        cfg_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic rand_word();
        int                 pick;
        logic [CMD_W-1:0]   cmd;
        logic [SRC_W-1:0]   idx;
        pick = $urandom_range(0, 99);
        if (pick < 20)      cmd = CMD_POLL;
        else if (pick < 55) cmd = CMD_SET_PEND;
        else if (pick < 70) cmd = CMD_CLR_PEND;
        else if (pick < 84) cmd = CMD_ENABLE;
        else if (pick < 94) cmd = CMD_DISABLE;
        else                cmd = CMD_RSVD_LO + CMD_W'($urandom_range(0, 2));
        if ($urandom_range(0, 99) < 6) idx = SRC_W'(NUM_SRC + $urandom_range(0, 3));
        else                           idx = SRC_W'($urandom_range(0, NUM_SRC - 1));
        send_word(cmd, idx, ($urandom_range(0, 9) == 0), LVL_W'($urandom_range(0, 15)));
    endtask

    task automatic test_reset_state();
        send_word(CMD_POLL, 5'd0, 1'b0, 4'd0);
        send_word(CMD_POLL, 5'd31, 1'b1, 4'd15);
        send_word(CMD_SET_PEND, 5'd27, 1'b0, 4'd0);
        send_word(CMD_SET_PEND, 5'd3, 1'b0, 4'd0);
        drain();
    endtask

    task automatic test_fixed_levels();
        send_word(CMD_SET_PEND, 5'd2, 1'b0, 4'd0);
        send_word(CMD_SET_PEND, 5'd0, 1'b0, 4'd0);
        send_word(CMD_SET_PEND, 5'd1, 1'b0, 4'd5);
        send_word(CMD_POLL, 5'd0, 1'b0, 4'd6);
        send_word(CMD_POLL, 5'd0, 1'b1, 4'd0);
        send_word(CMD_POLL, 5'd0, 1'b0, 4'd15);
        send_word(CMD_DISABLE, 5'd0, 1'b0, 4'd0);
        send_word(CMD_CLR_PEND, 5'd1, 1'b0, 4'd0);
        send_word(CMD_RSVD_LO, 5'd2, 1'b0, 4'd0);
        send_word(CMD_RSVD_MID, 5'd1, 1'b0, 4'd1);
        send_word(CMD_RSVD_HI, 5'd0, 1'b0, 4'd0);
        send_word(CMD_SET_PEND, 5'd28, 1'b0, 4'd0);
        send_word(CMD_CLR_PEND, 5'd30, 1'b0, 4'd0);
        send_word(CMD_DISABLE, 5'd31, 1'b0, 4'd0);
        send_word(CMD_ENABLE, 5'd29, 1'b0, 4'd0);
        send_word(CMD_ENABLE, 5'd0, 1'b0, 4'd1);
        send_word(CMD_CLR_PEND, 5'd0, 1'b0, 4'd0);
        send_word(CMD_CLR_PEND, 5'd2, 1'b0, 4'd0);
        drain();
    endtask

    task automatic test_config_levels();
        write_prio(CFG_PRIO_A, 16'hFFFF);
        write_prio(CFG_PRIO_B, 16'hFFFF);
        write_prio(CFG_PRIO_C, 16'hFFFF);
        write_prio(CFG_NONE, 16'h1234);
        send_word(CMD_SET_PEND, 5'd10, 1'b0, 4'd0);
        send_word(CMD_SET_PEND, 5'd26, 1'b0, 4'd0);
        send_word(CMD_SET_PEND, 5'd27, 1'b0, 4'd14);
        send_word(CMD_POLL, 5'd0, 1'b0, 4'd15);
        send_word(CMD_DISABLE, 5'd27, 1'b0, 4'd0);
        drain();
        // levels move, pending and enable bits stay put
        write_prio(CFG_PRIO_A, 16'hF000);
        write_prio(CFG_PRIO_B, 16'h0000);
        write_prio(CFG_PRIO_C, 16'h0000);
        send_word(CMD_POLL, 5'd0, 1'b0, 4'd0);
        send_word(CMD_ENABLE, 5'd27, 1'b0, 4'd0);
        drain();
    endtask

    task automatic test_stall_pressure();
        tx_bursty = 1'b0;
        @(posedge i_clk);
        hold_req = 300;
        repeat (40) rand_word();
        drain();
        tx_bursty = 1'b1;
    endtask

    task automatic test_random_phases();
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: begin
                    write_prio(CFG_PRIO_A, 16'hFFFF);
                    write_prio(CFG_PRIO_B, 16'hFFFF);
                    write_prio(CFG_PRIO_C, 16'hFFFF);
                end
                1: begin
                    write_prio(CFG_PRIO_A, 16'h0000);
                    write_prio(CFG_PRIO_B, 16'h0000);
                    write_prio(CFG_PRIO_C, 16'h0000);
                end
                default: begin
                    write_prio(CFG_PRIO_A, PRIO_W'($urandom));
                    write_prio(CFG_PRIO_B, PRIO_W'($urandom));
                    write_prio(CFG_PRIO_C, PRIO_W'($urandom));
                end
            endcase
            write_prio(CFG_NONE, PRIO_W'($urandom));
            rx_mode   = ph % 3;
            rx_pat    = 16'($urandom) | 16'h0001;
            tx_bursty = (ph % 4 != 3);
            repeat (250) rand_word();
            drain();
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        pend_bits     = '0;
        en_bits       = '1;
        prio_a        = '0;
        prio_b        = '0;
        prio_c        = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        test_reset_state();
        test_fixed_levels();
        test_config_levels();
        test_stall_pressure();
        test_random_phases();

        drain();
        repeat (10) @(posedge i_clk);
        $display("sent %0d words, checked %0d results, %0d register writes, %0d errors",
                 words_sent, words_seen, cfg_writes, err_cnt);
        $display("covered fixed and register levels, masks, block flag, ties, bad commands, "
                 , "out-of-range sources and a long output stall");
        if (err_cnt == 0) $display("TB_OK");
        else $display("TB_ERROR");
        $finish;
    end

endmodule

[sim.f]
src/pis_pkg.sv
src/pis_select.sv
src/priority_interrupt_selector_core.sv
src/pis_checker.sv
verif/tb_top.sv
